// ===== rtl/seg_pkg.sv =====
// ----------------------------------------------------------------------------
// seg_pkg: shared widths for the segment intersection pipeline
// Coordinate, difference, product and divider widths, derived from the
// coordinate format.
// ----------------------------------------------------------------------------
package seg_pkg;
	localparam int CW = 32;          // coordinate width
	localparam int DW = CW + 1;      // coordinate difference
	localparam int PW = 2 * DW;      // one exact product
	localparam int XW = PW + 2;      // cross, dot and sums of them
	localparam int MW = PW;          // magnitude of numerator or denominator
	localparam int HW = MW / 2;      // half magnitude for the split multiply
	localparam int QB = CW + 2;      // quotient bits before the result saturates
	localparam int RW = MW + QB;     // divider remainder width
	localparam int OW = QB + 2;      // signed offset plus start
	localparam int NIN = 8;          // coordinate fields in a request
endpackage

// ===== rtl/segment_intersection.sv =====
// ----------------------------------------------------------------------------
// segment_intersection: exact 2D line segment intersection
// Exact cross and dot products, collinear overlap handling, and a pipelined
// restoring divider that places the point with truncation and saturation.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                       tuser
// s_*      in   a_start_x,a_start_y,a_end_x,a_end_y,        allow_outside
//               b_start_x,b_start_y,b_end_x,b_end_y
// m_*      out  point_x,point_y                             hit,clipped
//
// One request enters per cycle while the output is not stalled.
// The divider retires one quotient bit per stage.
// The whole pipeline advances when the output register is empty or taken,
// so a stall freezes every stage and nothing is lost or repeated.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module segment_intersection import seg_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [255:0]    s_tdata,   // a_start_x,a_start_y,a_end_x,a_end_y,b_start_x..b_end_y
	input  logic [0:0]      s_tuser,   // allow_outside
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [63:0]     m_tdata,   // point_x, point_y
	output logic [1:0]      m_tuser    // hit, clipped
);

	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	logic signed [CW-1:0] fld [NIN];
	always_comb begin
		for (int i = 0; i < NIN; i++) begin
			fld[i] = s_tdata[i*CW +: CW];
		end
	end

	// Stage 1: differences.
	logic v_s1, out_s1;
	logic signed [CW-1:0] ax_s1, ay_s1;
	logic signed [DW-1:0] rx_s1, ry_s1, sx_s1, sy_s1, qx_s1, qy_s1;
	// Stage 2: products.
	logic v_s2, out_s2;
	logic signed [CW-1:0] ax_s2, ay_s2;
	logic signed [DW-1:0] rx_s2, ry_s2;
	logic signed [PW-1:0] rxsy_s2, rysx_s2, qxry_s2, qyrx_s2, qxsy_s2, qysx_s2;
	logic signed [PW-1:0] rxrx_s2, ryry_s2, qxrx_s2, qyry_s2, sxrx_s2, syry_s2;
	// Stage 3: cross and dot products.
	logic v_s3, out_s3;
	logic signed [CW-1:0] ax_s3, ay_s3;
	logic signed [DW-1:0] rx_s3, ry_s3;
	logic signed [XW-1:0] c12_s3, c31_s3, c32_s3, den_s3, a0_s3, sr_s3, a1_s3;
	// Stage 4: hit decision and operand selection.
	logic v_s4, hit_s4;
	logic signed [CW-1:0] ax_s4, ay_s4;
	logic signed [DW-1:0] rx_s4, ry_s4;
	logic signed [XW-1:0] num_s4, den_s4;
	// Stage 5: magnitudes and signs.
	logic v_s5, hit_s5, nx_s5, ny_s5;
	logic signed [CW-1:0] ax_s5, ay_s5;
	logic [DW-1:0] rxm_s5, rym_s5;
	logic [MW-1:0] numm_s5, denm_s5;
	// Stage 6: split products.
	logic v_s6, hit_s6, nx_s6, ny_s6;
	logic signed [CW-1:0] ax_s6, ay_s6;
	logic [MW-1:0] denm_s6;
	logic [PW-1:0] pxl_s6, pxh_s6, pyl_s6, pyh_s6;
	// Stage 7: full dividends.
	logic v_s7, hit_s7, nx_s7, ny_s7;
	logic signed [CW-1:0] ax_s7, ay_s7;
	logic [MW-1:0] denm_s7;
	logic [RW-1:0] px_s7, py_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
		end
	end

	// Signals for the stage 4 decision.
	logic signed [XW-1:0] num_col, lo_col;
	logic par, col_ok, col_miss, in32, in31, hit_d;

	always_comb begin
		par = (c12_s3 == '0);
		col_ok = (c31_s3 == '0) && (den_s3 != '0);
		if (sr_s3 >= 0) begin
			col_miss = (a0_s3 > den_s3) || (a1_s3 < 0);
		end else begin
			col_miss = (a1_s3 > den_s3) || (a0_s3 < 0);
		end
		lo_col = (a0_s3 <= a1_s3) ? a0_s3 : a1_s3;
		num_col = (lo_col < 0) ? '0 : lo_col;
		in32 = (c32_s3 == '0) || (c12_s3 > 0 && c32_s3 > 0 && c32_s3 <= c12_s3)
			|| (c12_s3 < 0 && c32_s3 < 0 && c32_s3 >= c12_s3);
		in31 = (c31_s3 == '0) || (c12_s3 > 0 && c31_s3 > 0 && c31_s3 <= c12_s3)
			|| (c12_s3 < 0 && c31_s3 < 0 && c31_s3 >= c12_s3);
		hit_d = par ? (col_ok && !col_miss) : (out_s3 || (in32 && in31));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= fld[0];
			ay_s1 <= fld[1];
			rx_s1 <= DW'(fld[2]) - DW'(fld[0]);
			ry_s1 <= DW'(fld[3]) - DW'(fld[1]);
			sx_s1 <= DW'(fld[6]) - DW'(fld[4]);
			sy_s1 <= DW'(fld[7]) - DW'(fld[5]);
			qx_s1 <= DW'(fld[4]) - DW'(fld[0]);
			qy_s1 <= DW'(fld[5]) - DW'(fld[1]);
			out_s1 <= s_tuser[0];

			ax_s2 <= ax_s1; ay_s2 <= ay_s1; rx_s2 <= rx_s1; ry_s2 <= ry_s1;
			out_s2 <= out_s1;
			rxsy_s2 <= rx_s1 * sy_s1; rysx_s2 <= ry_s1 * sx_s1;
			qxry_s2 <= qx_s1 * ry_s1; qyrx_s2 <= qy_s1 * rx_s1;
			qxsy_s2 <= qx_s1 * sy_s1; qysx_s2 <= qy_s1 * sx_s1;
			rxrx_s2 <= rx_s1 * rx_s1; ryry_s2 <= ry_s1 * ry_s1;
			qxrx_s2 <= qx_s1 * rx_s1; qyry_s2 <= qy_s1 * ry_s1;
			sxrx_s2 <= sx_s1 * rx_s1; syry_s2 <= sy_s1 * ry_s1;

			ax_s3 <= ax_s2; ay_s3 <= ay_s2; rx_s3 <= rx_s2; ry_s3 <= ry_s2;
			out_s3 <= out_s2;
			c12_s3 <= XW'(rxsy_s2) - XW'(rysx_s2);
			c31_s3 <= XW'(qxry_s2) - XW'(qyrx_s2);
			c32_s3 <= XW'(qxsy_s2) - XW'(qysx_s2);
			den_s3 <= XW'(rxrx_s2) + XW'(ryry_s2);
			a0_s3  <= XW'(qxrx_s2) + XW'(qyry_s2);
			sr_s3  <= XW'(sxrx_s2) + XW'(syry_s2);
			a1_s3  <= XW'(qxrx_s2) + XW'(qyry_s2) + XW'(sxrx_s2) + XW'(syry_s2);

			ax_s4 <= ax_s3; ay_s4 <= ay_s3; rx_s4 <= rx_s3; ry_s4 <= ry_s3;
			hit_s4 <= hit_d;
			num_s4 <= par ? num_col : c32_s3;
			den_s4 <= par ? den_s3 : c12_s3;

			ax_s5 <= ax_s4; ay_s5 <= ay_s4; hit_s5 <= hit_s4;
			rxm_s5 <= (rx_s4 < 0) ? DW'(-rx_s4) : DW'(rx_s4);
			rym_s5 <= (ry_s4 < 0) ? DW'(-ry_s4) : DW'(ry_s4);
			numm_s5 <= (num_s4 < 0) ? MW'(-num_s4) : MW'(num_s4);
			denm_s5 <= (den_s4 < 0) ? MW'(-den_s4) : MW'(den_s4);
			nx_s5 <= (rx_s4 < 0) ^ (num_s4 < 0) ^ (den_s4 < 0);
			ny_s5 <= (ry_s4 < 0) ^ (num_s4 < 0) ^ (den_s4 < 0);

			ax_s6 <= ax_s5; ay_s6 <= ay_s5; hit_s6 <= hit_s5;
			nx_s6 <= nx_s5; ny_s6 <= ny_s5; denm_s6 <= denm_s5;
			pxl_s6 <= PW'(rxm_s5) * PW'(numm_s5[HW-1:0]);
			pxh_s6 <= PW'(rxm_s5) * PW'(numm_s5[MW-1:HW]);
			pyl_s6 <= PW'(rym_s5) * PW'(numm_s5[HW-1:0]);
			pyh_s6 <= PW'(rym_s5) * PW'(numm_s5[MW-1:HW]);

			ax_s7 <= ax_s6; ay_s7 <= ay_s6; hit_s7 <= hit_s6;
			nx_s7 <= nx_s6; ny_s7 <= ny_s6; denm_s7 <= denm_s6;
			px_s7 <= RW'(pxl_s6) + (RW'(pxh_s6) << HW);
			py_s7 <= RW'(pyl_s6) + (RW'(pyh_s6) << HW);
		end
	end

	// Divider: entry 0 is loaded with the overflow check, entry k holds the
	// state after k quotient bits, most significant first.
	logic v_sd [QB+1];
	logic hit_sd [QB+1], nx_sd [QB+1], ny_sd [QB+1], ovx_sd [QB+1], ovy_sd [QB+1];
	logic signed [CW-1:0] ax_sd [QB+1], ay_sd [QB+1];
	logic [MW-1:0] d_sd [QB+1];
	logic [RW-1:0] rx_sd [QB+1], ry_sd [QB+1];
	logic [QB-1:0] qx_sd [QB+1], qy_sd [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd[0] <= 1'b0;
		end else if (en) begin
			v_sd[0] <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_sd[0] <= hit_s7; nx_sd[0] <= nx_s7; ny_sd[0] <= ny_s7;
			ax_sd[0] <= ax_s7; ay_sd[0] <= ay_s7; d_sd[0] <= denm_s7;
			rx_sd[0] <= px_s7; ry_sd[0] <= py_s7;
			qx_sd[0] <= '0; qy_sd[0] <= '0;
			ovx_sd[0] <= (px_s7 >= (RW'(denm_s7) << QB));
			ovy_sd[0] <= (py_s7 >= (RW'(denm_s7) << QB));
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_div
		logic [RW-1:0] dsh;
		assign dsh = RW'(d_sd[k-1]) << (QB - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k] <= 1'b0;
			end else if (en) begin
				v_sd[k] <= v_sd[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hit_sd[k] <= hit_sd[k-1]; nx_sd[k] <= nx_sd[k-1]; ny_sd[k] <= ny_sd[k-1];
				ovx_sd[k] <= ovx_sd[k-1]; ovy_sd[k] <= ovy_sd[k-1];
				ax_sd[k] <= ax_sd[k-1]; ay_sd[k] <= ay_sd[k-1]; d_sd[k] <= d_sd[k-1];
				if (rx_sd[k-1] >= dsh) begin
					rx_sd[k] <= rx_sd[k-1] - dsh;
					qx_sd[k] <= qx_sd[k-1] | (QB'(1) << (QB - k));
				end else begin
					rx_sd[k] <= rx_sd[k-1];
					qx_sd[k] <= qx_sd[k-1];
				end
				if (ry_sd[k-1] >= dsh) begin
					ry_sd[k] <= ry_sd[k-1] - dsh;
					qy_sd[k] <= qy_sd[k-1] | (QB'(1) << (QB - k));
				end else begin
					ry_sd[k] <= ry_sd[k-1];
					qy_sd[k] <= qy_sd[k-1];
				end
			end
		end
	end

	// Output stage: add the offset to the start and saturate.
	localparam logic signed [OW-1:0] MAXV = OW'((64'sd1 <<< (CW - 1)) - 1);
	localparam logic signed [OW-1:0] MINV = -MAXV - OW'(1);

	logic signed [OW-1:0] offx, offy, sumx, sumy;
	logic signed [CW-1:0] ptx, pty;
	logic satx, saty;

	always_comb begin
		offx = nx_sd[QB] ? -OW'(qx_sd[QB]) : OW'(qx_sd[QB]);
		offy = ny_sd[QB] ? -OW'(qy_sd[QB]) : OW'(qy_sd[QB]);
		sumx = OW'(ax_sd[QB]) + offx;
		sumy = OW'(ay_sd[QB]) + offy;
		satx = 1'b1;
		saty = 1'b1;
		if (ovx_sd[QB]) begin
			ptx = nx_sd[QB] ? CW'(MINV) : CW'(MAXV);
		end else if (sumx > MAXV) begin
			ptx = CW'(MAXV);
		end else if (sumx < MINV) begin
			ptx = CW'(MINV);
		end else begin
			ptx = CW'(sumx);
			satx = 1'b0;
		end
		if (ovy_sd[QB]) begin
			pty = ny_sd[QB] ? CW'(MINV) : CW'(MAXV);
		end else if (sumy > MAXV) begin
			pty = CW'(MAXV);
		end else if (sumy < MINV) begin
			pty = CW'(MINV);
		end else begin
			pty = CW'(sumy);
			saty = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= v_sd[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (hit_sd[QB]) begin
				m_tdata <= {pty, ptx};
				m_tuser <= {satx | saty, 1'b1};
			end else begin
				m_tdata <= '0;
				m_tuser <= '0;
			end
		end
	end

`ifndef ASSERT_OFF
	// A miss carries a zero point and no clip mark.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
		else $error("miss with nonzero point");

	// A clipped point has a coordinate at a range limit.
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[31:0] == 32'h7fffffff
		|| m_tdata[31:0] == 32'h80000000 || m_tdata[63:32] == 32'h7fffffff
		|| m_tdata[63:32] == 32'h80000000)
		else $error("clip without saturated coordinate");

	// For a hit without x overflow the final x remainder is below the divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_sd[QB] && hit_sd[QB] && !ovx_sd[QB] |-> rx_sd[QB] < RW'(d_sd[QB]))
		else $error("divider remainder not reduced");

	// A stalled output freezes the divider tail.
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(qx_sd[QB]) && $stable(v_sd[QB]))
		else $error("pipeline moved during stall");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for segment_intersection
// Drives random and directed segment pairs through the stream input, predicts
// hit, point and saturation exactly with wide integer math, and compares every
// result in order while both sides idle at random until a final calm phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class hit_scoreboard;
	logic [65:0] pending_q[$];
	int mismatches;

	function void note_request(logic [65:0] expected);
		pending_q = {pending_q, expected};
	endfunction

	function void check_result(logic [63:0] data, logic [1:0] user);
		logic [65:0] exp_val;
		if (pending_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result data=%h user=%b", data, user);
		end else begin
			exp_val = pending_q.pop_front();
			if (exp_val != {user, data}) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected hit=%b clip=%b x=%h y=%h, got hit=%b clip=%b x=%h y=%h",
						exp_val[64], exp_val[65], exp_val[31:0], exp_val[63:32],
						user[0], user[1], data[31:0], data[63:32]);
			end
		end
	endfunction
endclass

module tb;
	import seg_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [255:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [63:0] m_tdata;
	logic [1:0] m_tuser;

	hit_scoreboard sb;
	bit calm_phase;
	bit hold_sink;

	always #1 clk = ~clk;

	segment_intersection dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// Offset start + v*n/d, truncated toward zero, saturated to 32 bits.
	function automatic logic [32:0] place_coord(longint start, longint v,
		logic signed [255:0] n, logic signed [255:0] d);
		logic signed [255:0] p;
		logic signed [255:0] maxv;
		logic signed [255:0] minv;
		maxv = 256'sd2147483647;
		minv = -256'sd2147483648;
		p = v;
		p = (p * n) / d;
		p = p + start;
		if (p > maxv) return {1'b1, 32'h7fffffff};
		if (p < minv) return {1'b1, 32'h80000000};
		return {1'b0, p[31:0]};
	endfunction

	function automatic bit in_unit_range(logic signed [255:0] n, logic signed [255:0] d);
		if (n == 0) return 1;
		if (d > 0) return n > 0 && n <= d;
		return n < 0 && n >= d;
	endfunction

	function automatic logic [65:0] predict_crossing(logic [255:0] data, bit outside);
		longint ax, ay, rx, ry, bx, by, sx, sy, qx, qy;
		logic signed [255:0] c12, c31, c32, num, den, a0, a1, sr;
		logic [32:0] px, py;
		ax = longint'(signed'(data[31:0]));
		ay = longint'(signed'(data[63:32]));
		rx = longint'(signed'(data[95:64])) - ax;
		ry = longint'(signed'(data[127:96])) - ay;
		bx = longint'(signed'(data[159:128]));
		by = longint'(signed'(data[191:160]));
		sx = longint'(signed'(data[223:192])) - bx;
		sy = longint'(signed'(data[255:224])) - by;
		qx = bx - ax;
		qy = by - ay;
		c12 = (256'(signed'(rx)) * sy) - (256'(signed'(ry)) * sx);
		c31 = (256'(signed'(qx)) * ry) - (256'(signed'(qy)) * rx);
		c32 = (256'(signed'(qx)) * sy) - (256'(signed'(qy)) * sx);
		if (c12 == 0) begin
			if (c31 != 0) return '0;
			den = (256'(signed'(rx)) * rx) + (256'(signed'(ry)) * ry);
			if (den == 0) return '0;
			a0 = (256'(signed'(qx)) * rx) + (256'(signed'(qy)) * ry);
			sr = (256'(signed'(sx)) * rx) + (256'(signed'(sy)) * ry);
			a1 = a0 + sr;
			if (sr >= 0) begin
				if (a0 > den || a1 < 0) return '0;
			end else begin
				if (a1 > den || a0 < 0) return '0;
			end
			num = (a0 <= a1) ? a0 : a1;
			if (num < 0) num = 0;
		end else begin
			if (!outside && (!in_unit_range(c32, c12) || !in_unit_range(c31, c12)))
				return '0;
			num = c32;
			den = c12;
		end
		px = place_coord(ax, rx, num, den);
		py = place_coord(ay, ry, num, den);
		return {px[32] | py[32], 1'b1, py[31:0], px[31:0]};
	endfunction

	task automatic send_pair(logic [255:0] data, bit outside);
		if (!calm_phase && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= data;
		s_tuser <= outside;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(predict_crossing(data, outside));
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 3) == 0 ? 32'h80000000 : 32'h7fffffff;
			default: return 32'(int'($urandom_range(0, 16)) - 8) << 16;
		endcase
	endfunction

	// Collinear pairs near the origin, built one time in four, get past the early exits.
	function automatic logic [255:0] rand_pair();
		logic [255:0] d;
		int k;
		int dx, dy;
		for (int i = 0; i < 8; i++) d[i*32 +: 32] = rand_coord();
		k = $urandom_range(0, 3);
		if (k == 0) begin
			dx = int'($urandom_range(0, 8)) - 4;
			dy = int'($urandom_range(0, 8)) - 4;
			d[63:0] = {32'(int'($urandom_range(0, 20)) - 10), 32'(int'($urandom_range(0, 20)) - 10)};
			d[95:64] = d[31:0] + 32'(dx * 3);
			d[127:96] = d[63:32] + 32'(dy * 3);
			d[159:128] = d[31:0] + 32'(dx * (int'($urandom_range(0, 8)) - 4));
			d[191:160] = d[63:32] + 32'(dy * (int'(d[159:128] - d[31:0]) / (dx == 0 ? 1 : dx)));
			if (dx == 0) d[191:160] = d[63:32] + 32'(int'($urandom_range(0, 8)) - 4);
			d[223:192] = d[159:128] + 32'(dx * (int'($urandom_range(0, 8)) - 4));
			d[255:224] = d[191:160] + 32'(dy * (int'(d[223:192] - d[159:128]) / (dx == 0 ? 1 : dx)));
		end
		return d;
	endfunction

	// Receiver: random stalls, plus one long hold requested by the stimulus.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				m_tready <= 0;
				repeat (200) @(posedge clk);
				hold_sink = 0;
			end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
				m_tready <= 0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			m_tready <= 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	initial begin
		#400000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic [255:0] d;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: crossing, outside, collinear overlap and gap, parallel,
		// zero-length first segment, extremes and saturation.
		send_pair({32'h00000000, 32'h00020000, 32'h00010000, 32'h00010000,
			32'h00020000, 32'h00020000, 32'h00000000, 32'h00000000}, 0);
		send_pair({32'h00000000, 32'h00050000, 32'h00010000, 32'h00040000,
			32'h00020000, 32'h00020000, 32'h00000000, 32'h00000000}, 0);
		send_pair({32'h00000000, 32'h00050000, 32'h00010000, 32'h00040000,
			32'h00020000, 32'h00020000, 32'h00000000, 32'h00000000}, 1);
		send_pair({32'h0, 32'h00030000, 32'h0, 32'h00010000,
			32'h0, 32'h00020000, 32'h0, 32'h0}, 0);
		send_pair({32'h0, 32'h00010000, 32'h0, 32'h00030000,
			32'h0, 32'h00020000, 32'h0, 32'h0}, 0);
		send_pair({32'h0, 32'h00050000, 32'h0, 32'h00030000,
			32'h0, 32'h00020000, 32'h0, 32'h0}, 1);
		send_pair({32'h00010000, 32'h00020000, 32'h00010000, 32'h00000000,
			32'h0, 32'h00020000, 32'h0, 32'h0}, 0);
		send_pair({32'h0, 32'h00010000, 32'h0, 32'h00010000,
			32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000}, 0);
		send_pair({32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000}, 0);
		send_pair({32'h7fffffff, 32'h7fffff00, 32'h80000000, 32'h80000001,
			32'h00000001, 32'h00000000, 32'h00000000, 32'h00000001}, 1);
		send_pair({32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000}, 0);
		send_pair({32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff}, 1);
		// Sender waits until the pipeline drains.
		s_tvalid <= 0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		hold_sink = 1;
		for (int i = 0; i < 1300; i++) begin
			if (i == 1100) calm_phase = 1;
			d = rand_pair();
			send_pair(d, $urandom_range(0, 1));
		end
		s_tvalid <= 0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
